// ===== rtl/rlab_pkg.sv =====
// Shared types and constants for the run-length alpha sprite line blender.
// No dependencies; imported by every module of the block.
package rlab_pkg;

    localparam int MAX_WIDTH = 1023;

    localparam int WIDTH_W = 10;
    localparam int RUN_W   = 8;
    localparam int ALPHA_W = 5;
    localparam int COUNT_W = 11;
    localparam int PIXEL_W = 16;
    localparam int CHAN_W  = 5;

    localparam logic [7:0]         ALPHA_SKIP = 8'h1f;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_MAX  = {WIDTH_W{1'b1}};

    // Clamp applied to line_width when a line starts
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT =
        (MAX_WIDTH > (2 ** WIDTH_W) - 1) ? WIDTH_MAX : WIDTH_W'(MAX_WIDTH);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_SKIP   = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [PIXEL_W-1:0] pixel;
        logic [RUN_W-1:0]   advance;
        logic               line_end;
        logic [COUNT_W-1:0] line_words;
        logic               format_error;
    } result_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

// ===== rtl/rlab_blend.sv =====
// Per-channel RGB555 alpha blend: src + floor(dest_channel * alpha / 32).
// Depends on rlab_pkg.
module rlab_blend (
    input  logic [15:0] src,
    input  logic [15:0] dst,
    input  logic [4:0]  alpha,
    output logic [15:0] pixel
);
    import rlab_pkg::*;

    logic [2*CHAN_W-1:0] prod0;
    logic [2*CHAN_W-1:0] prod1;
    logic [2*CHAN_W-1:0] prod2;
    logic [3*CHAN_W-1:0] add;

    assign prod0 = dst[4:0]   * alpha;
    assign prod1 = dst[9:5]   * alpha;
    assign prod2 = dst[14:10] * alpha;

    // Keep the high five bits of each product: the divide by 32
    assign add = {prod2[2*CHAN_W-1:CHAN_W], prod1[2*CHAN_W-1:CHAN_W],
                  prod0[2*CHAN_W-1:CHAN_W]};

    // 16-bit sum wraps
    assign pixel = src + {1'b0, add};

endmodule

// ===== rtl/rlab_decode.sv =====
// Run decoder: line state, width register and the result of each transaction.
// Depends on rlab_pkg and rlab_blend.
module rlab_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    line_width_we,
    input  logic [9:0]              line_width_data,
    input  logic                    fire,
    input  logic [15:0]             stream_word,
    input  logic [15:0]             dest_pixel,
    output rlab_pkg::result_t       result
);
    import rlab_pkg::*;

    logic [WIDTH_W-1:0] line_width_reg;
    logic [WIDTH_W-1:0] width_left_reg, width_left_next;
    logic [RUN_W-1:0]   run_left_reg, run_left_next;
    logic [ALPHA_W-1:0] run_alpha_reg, run_alpha_next;
    logic [COUNT_W-1:0] word_count_reg, word_count_next;

    logic [WIDTH_W-1:0] width_start;
    logic [WIDTH_W-1:0] width_base;
    logic [WIDTH_W-1:0] run_len_w;
    logic [7:0]         hdr_alpha;
    logic [RUN_W-1:0]   hdr_len;
    logic [COUNT_W-1:0] count_inc;
    logic [PIXEL_W-1:0] blended;
    logic               is_header;

    assign hdr_alpha   = stream_word[7:0];
    assign hdr_len     = stream_word[15:8];
    assign run_len_w   = WIDTH_W'(hdr_len);
    assign is_header   = (run_left_reg == '0);
    assign width_start = (line_width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : line_width_reg;
    assign width_base  = (word_count_reg == '0) ? width_start : width_left_reg;
    assign count_inc   = (word_count_reg == COUNT_MAX) ? COUNT_MAX : word_count_reg + 1'b1;

    rlab_blend u_blend (
        .src   (stream_word),
        .dst   (dest_pixel),
        .alpha (run_alpha_reg),
        .pixel (blended)
    );

    always_comb
    begin
        result          = '0;
        width_left_next = width_left_reg;
        run_left_next   = run_left_reg;
        run_alpha_next  = run_alpha_reg;
        word_count_next = count_inc;

        if (is_header)
        begin
            width_left_next = (width_base > run_len_w) ? width_base - run_len_w : '0;
            if (hdr_alpha >= ALPHA_SKIP)
            begin
                result.kind         = KIND_SKIP;
                result.advance      = hdr_len;
                result.format_error = (hdr_alpha > ALPHA_SKIP);
            end
            else
            begin
                result.kind    = KIND_HEADER;
                run_left_next  = hdr_len;
                run_alpha_next = hdr_alpha[ALPHA_W-1:0];
            end
        end
        else
        begin
            result.kind    = KIND_PIXEL;
            result.pixel   = blended;
            result.advance = RUN_W'(1);
            run_left_next  = run_left_reg - 1'b1;
        end

        // Close the line once the runs cover the width and the last run drains
        if (run_left_next == '0 && width_left_next == '0)
        begin
            result.line_end   = 1'b1;
            result.line_words = count_inc;
            word_count_next   = '0;
            run_alpha_next    = '0;
            width_left_next   = width_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= WIDTH_W'(256);
            width_left_reg <= WIDTH_W'(256);
            run_left_reg   <= '0;
            run_alpha_reg  <= '0;
            word_count_reg <= '0;
        end
        else
        begin
            if (line_width_we)
            begin
                line_width_reg <= line_width_data;
            end
            if (fire)
            begin
                width_left_reg <= width_left_next;
                run_left_reg   <= run_left_next;
                run_alpha_reg  <= run_alpha_next;
                word_count_reg <= word_count_next;
            end
        end
    end

endmodule

// ===== rtl/rlab_skid.sv =====
// Result register with a skid stage, so a transaction is taken while a result waits.
// Depends on rlab_pkg.
module rlab_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  rlab_pkg::result_t     in_data,
    output logic                  can_accept,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rlab_pkg::result_t     out_data,
    output rlab_pkg::buf_status_t status
);
    import rlab_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    out_fire;

    assign out_fire   = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;
    assign status     = '{main_valid: main_valid_reg, skid_valid: skid_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Refill the output from the skid stage
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
            begin
                skid_reg <= in_data;
            end
            else
            begin
                main_reg <= in_data;
            end
        end
    end

endmodule

// ===== rtl/rle_alpha_sprite_line_blender.sv =====
// Top level of the run-length alpha sprite line blender.
// Depends on rlab_pkg, rlab_decode, rlab_blend and rlab_skid.
//
//   Channel   Handshake                    Payload
//   word      word_valid / word_ready      stream_word, dest_pixel
//   result    result_valid / result_ready  item_kind, pixel_out, dest_advance,
//                                          line_end, line_words, format_error
//   config    line_width_we                line_width_data
//
// One stream word per cycle while word_ready is high; results are registered.
// The decode and blend of a word sit between the input port and the result register.
// A two-entry output buffer keeps word_ready high in a stall until the skid fills.
// Reset clears the run state and loads a line width of 256; no clearing pass.
module rle_alpha_sprite_line_blender (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_width_we,
    input  logic [9:0]  line_width_data,
    input  logic        word_valid,
    output logic        word_ready,
    input  logic [15:0] stream_word,
    input  logic [15:0] dest_pixel,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  item_kind,
    output logic [15:0] pixel_out,
    output logic [7:0]  dest_advance,
    output logic        line_end,
    output logic [10:0] line_words,
    output logic        format_error
);
    import rlab_pkg::*;

    result_t     dec_result;
    result_t     out_result;
    buf_status_t buf_status;
    logic        word_fire;

    assign word_fire = word_valid && word_ready;

    rlab_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_width_we   (line_width_we),
        .line_width_data (line_width_data),
        .fire            (word_fire),
        .stream_word     (stream_word),
        .dest_pixel      (dest_pixel),
        .result          (dec_result)
    );

    rlab_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (word_fire),
        .in_data    (dec_result),
        .can_accept (word_ready),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_data   (out_result),
        .status     (buf_status)
    );

    assign item_kind    = out_result.kind;
    assign pixel_out    = out_result.pixel;
    assign dest_advance = out_result.advance;
    assign line_end     = out_result.line_end;
    assign line_words   = out_result.line_words;
    assign format_error = out_result.format_error;

    // Skid stage holds data only behind a full output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid |-> buf_status.main_valid)
        else $error("skid stage valid with empty output register");

    // A stalled full buffer refuses new words
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid && !result_ready |=> !word_ready)
        else $error("word accepted while buffer full");

    a_pixel_advance: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && item_kind == KIND_PIXEL |-> dest_advance == 8'd1)
        else $error("pixel result without unit advance");

    a_error_is_skip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && format_error |-> item_kind == KIND_SKIP)
        else $error("format error on a non-skip result");

    a_words_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !line_end |-> line_words == 11'd0)
        else $error("word count shown before line end");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the run-length alpha sprite line blender.
// Needs rlab_pkg and rle_alpha_sprite_line_blender; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module testbench;
    import rlab_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SEGMENT_WORDS = 60;
    localparam int LONG_LINE_WORDS = 40;

    class line_blend_scoreboard;
        logic [WIDTH_W-1:0] line_width;
        logic [WIDTH_W-1:0] width_left;
        logic [RUN_W-1:0]   run_left;
        logic [ALPHA_W-1:0] run_alpha;
        logic [COUNT_W-1:0] word_count;
        result_t            expected_results[$];
        int                 mismatches;
        int                 results_seen;
        int                 words_seen;
        int                 lines_seen;

        function new();
            line_width = 10'd256;
            width_left = 10'd256;
            run_left = '0;
            run_alpha = '0;
            word_count = '0;
            mismatches = 0;
            results_seen = 0;
            words_seen = 0;
            lines_seen = 0;
        endfunction

        function logic [WIDTH_W-1:0] clamped_width();
            return (line_width > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : line_width;
        endfunction

        // Premultiplied source plus floor(dest * alpha / 32) per channel, sum wraps at 16 bits
        function logic [PIXEL_W-1:0] blend_pixel(logic [PIXEL_W-1:0] src,
                                                 logic [PIXEL_W-1:0] dst,
                                                 logic [ALPHA_W-1:0] alpha);
            logic [PIXEL_W-1:0] add;
            logic [9:0]         prod;
            add = '0;
            for (int c = 0; c < 3; c++)
            begin
                prod = dst[c*CHAN_W +: CHAN_W] * alpha;
                add[c*CHAN_W +: CHAN_W] = prod[9:5];
            end
            return src + add;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_word(logic [PIXEL_W-1:0] word, logic [PIXEL_W-1:0] dst);
            result_t    r;
            logic [7:0] alpha;
            logic [7:0] len;
            r = '0;
            alpha = word[7:0];
            len = word[15:8];
            if (run_left == 0)
            begin
                if (word_count == 0)
                    width_left = clamped_width();
                width_left = (width_left > len) ? width_left - len : '0;
                if (alpha >= ALPHA_SKIP)
                begin
                    r.kind = KIND_SKIP;
                    r.advance = len;
                    r.format_error = (alpha > ALPHA_SKIP);
                end
                else
                begin
                    r.kind = KIND_HEADER;
                    run_left = len;
                    run_alpha = alpha[ALPHA_W-1:0];
                end
            end
            else
            begin
                r.kind = KIND_PIXEL;
                r.pixel = blend_pixel(word, dst, run_alpha);
                r.advance = 8'd1;
                run_left = run_left - 1'b1;
            end
            if (word_count != COUNT_MAX)
                word_count = word_count + 1'b1;
            if (run_left == 0 && width_left == 0)
            begin
                r.line_end = 1'b1;
                r.line_words = word_count;
                word_count = '0;
                run_alpha = '0;
                width_left = clamped_width();
                lines_seen++;
            end
            expected_results.push_back(r);
            words_seen++;
        endfunction

        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            $display("Mismatch on result %0d: %s is 0x%0h, want 0x%0h",
                     results_seen, field, got, want);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, item_kind", 16'(got.kind), 16'h0);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("item_kind", 16'(got.kind), 16'(want.kind));
            if (got.pixel !== want.pixel)
                report_mismatch("pixel_out", got.pixel, want.pixel);
            if (got.advance !== want.advance)
                report_mismatch("dest_advance", 16'(got.advance), 16'(want.advance));
            if (got.line_end !== want.line_end)
                report_mismatch("line_end", 16'(got.line_end), 16'(want.line_end));
            if (got.line_words !== want.line_words)
                report_mismatch("line_words", 16'(got.line_words), 16'(want.line_words));
            if (got.format_error !== want.format_error)
                report_mismatch("format_error", 16'(got.format_error),
                                16'(want.format_error));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        line_width_we;
    logic [9:0]  line_width_data;
    logic        word_valid;
    logic        word_ready;
    logic [15:0] stream_word;
    logic [15:0] dest_pixel;
    logic        result_valid;
    logic        result_ready;
    logic [1:0]  item_kind;
    logic [15:0] pixel_out;
    logic [7:0]  dest_advance;
    logic        line_end;
    logic [10:0] line_words;
    logic        format_error;

    line_blend_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;
    int widths_set = 0;

    rle_alpha_sprite_line_blender i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_width_we   (line_width_we),
        .line_width_data (line_width_data),
        .word_valid      (word_valid),
        .word_ready      (word_ready),
        .stream_word     (stream_word),
        .dest_pixel      (dest_pixel),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .item_kind       (item_kind),
        .pixel_out       (pixel_out),
        .dest_advance    (dest_advance),
        .line_end        (line_end),
        .line_words      (line_words),
        .format_error    (format_error)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                result_ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check results before noting the word accepted on the same edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got.kind = item_kind_t'(item_kind);
                got.pixel = pixel_out;
                got.advance = dest_advance;
                got.line_end = line_end;
                got.line_words = line_words;
                got.format_error = format_error;
                sb.check_result(got);
            end
            if (word_valid && word_ready)
                sb.note_word(stream_word, dest_pixel);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (word_valid && word_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function logic [15:0] header_word(int len, int alpha);
        return {8'(len), 8'(alpha)};
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction
    task send_word(logic [15:0] word, logic [15:0] dst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_valid <= 1'b0;
            @(negedge clk);
        end
        word_valid <= 1'b1;
        stream_word <= word;
        dest_pixel <= dst;
        do
            @(posedge clk);
        while (!word_ready);
        @(negedge clk);
    endtask

    // Picks a pixel inside a run, else a header, mostly sized against the width still open
    task send_random_word();
        logic [15:0] word;
        int          open_width;
        int          cap;
        int          len;
        int          alpha;
        int          pick;
        if (sb.run_left != 0)
        begin
            if ($urandom_range(2) == 0)
                word = 16'($urandom);
            else
                word = 16'($urandom_range(16'h3fff));
        end
        else
        begin
            open_width = (sb.word_count == 0) ? sb.line_width : sb.width_left;
            pick = $urandom_range(99);
            if (pick < 8)
                len = 0;
            else if (pick < 18)
                len = $urandom_range(255);
            else if (pick < 35)
                len = (open_width > 255) ? 255 : ((open_width < 1) ? 1 : open_width);
            else
            begin
                cap = (open_width > 64) ? 64 : ((open_width < 1) ? 1 : open_width);
                len = $urandom_range(cap, 1);
            end
            pick = $urandom_range(99);
            if (pick < 20)
                alpha = ALPHA_SKIP;
            else if (pick < 27)
                alpha = $urandom_range(255, 32);
            else
                alpha = $urandom_range(30);
            word = header_word(len, alpha);
        end
        send_word(word, 16'($urandom));
    endtask

    // Drop valid and wait until every expected result is in
    task drain();
        word_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_width(logic [9:0] width);
        line_width_we <= 1'b1;
        line_width_data <= width;
        @(negedge clk);
        line_width_we <= 1'b0;
        sb.line_width = width;
        widths_set++;
    endtask

    initial
    begin
        logic [9:0] width;
        rst_n = 1'b0;
        line_width_we = 1'b0;
        line_width_data = '0;
        word_valid = 1'b0;
        stream_word = '0;
        dest_pixel = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset width of 256: a skip of 255 then a skip of 1 closes the line
        send_word(header_word(255, ALPHA_SKIP), 16'h0);
        send_word(header_word(1, ALPHA_SKIP), 16'h0);
        drain();

        write_width(10'd12);
        send_word(header_word(1, 0), 16'hffff);
        send_word(16'hffff, 16'hffff);
        send_word(header_word(1, 1), 16'h0);
        send_word(16'h1234, 16'hffff);
        send_word(header_word(1, 30), 16'h0);
        send_word(16'h8000, 16'h7fff);
        send_word(header_word(1, 2), 16'h0);
        send_word(16'h7c1f, 16'h56b5);
        send_word(header_word(1, 4), 16'h0);
        send_word(16'($urandom), 16'($urandom));
        send_word(header_word(1, 8), 16'h0);
        send_word(16'($urandom), 16'($urandom));
        send_word(header_word(1, 16), 16'h0);
        send_word(16'h0000, 16'h7fff);
        send_word(header_word(2, ALPHA_SKIP), 16'h0);
        // zero-length runs, blended and skipped
        send_word(header_word(0, 5), 16'h0);
        send_word(header_word(0, ALPHA_SKIP), 16'h0);
        // alpha above 31 flags an error and skips
        send_word(header_word(1, 32), 16'h0);
        send_word(header_word(0, 255), 16'h0);
        // run longer than the width left: all pixels still come out
        send_word(header_word(3, 9), 16'h0);
        send_word(16'hffff, 16'h8000);
        send_word(16'h0421, 16'h7fff);
        send_word(16'h5555, 16'h2aaa);
        drain();

        write_width(10'd0);
        send_word(header_word(0, ALPHA_SKIP), 16'h0);
        send_word(header_word(1, 7), 16'h0);
        send_word(16'h7fff, 16'h7fff);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 72 : 0);
            recv_idle_pct = (phase == 0) ? 72 : ((phase == 1) ? 25 : 0);
            if (phase == 2)
                hold_off_left = HOLD_OFF_CYCLES;
            for (int k = 0; k < 4; k++)
            begin
                if (k == 2)
                    width = (phase == 0) ? 10'd1 :
                            ((phase == 1) ? 10'(MAX_WIDTH) : 10'($urandom_range(1022, 65)));
                else if (k == 3)
                    width = 10'($urandom_range(16, 1));
                else
                    width = 10'($urandom_range(64, 1));
                write_width(width);
                repeat (SEGMENT_WORDS) send_random_word();
                drain();
            end
        end

        // Open a line with zero-length runs, then close it with random runs
        write_width(10'd5);
        repeat (LONG_LINE_WORDS)
            send_word(header_word(0, $urandom_range(255)), 16'($urandom));
        while (sb.word_count != 0)
            send_random_word();
        drain();

        $display("Covered %0d stream words, %0d results, %0d completed lines, %0d widths.",
                 sb.words_seen, sb.results_seen, sb.lines_seen, widths_set);
        $display("Idle mixes: sender-heavy, receiver-heavy, none; one long receiver hold-off.");
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
